>>> rtl/breakpoint_segment_fraction_unit_assert.svh
// ---------------------------------------------------------------------------
// Breakpoint segment fraction unit - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BREAKPOINT_SEGMENT_FRACTION_UNIT_ASSERT_SVH
`define BREAKPOINT_SEGMENT_FRACTION_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define BSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bsf_pkg.sv
// ---------------------------------------------------------------------------
// Breakpoint segment fraction package
// Sizes, codes, types and the format key function shared by the unit.
// ---------------------------------------------------------------------------
package bsf_pkg;

  localparam int NUM_TABLES = 4;
  localparam int MAX_POINTS = 32;

  localparam int TBL_W  = $clog2(NUM_TABLES);
  localparam int PTR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = PTR_W + 1;
  localparam int ADDR_W = TBL_W + PTR_W;

  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int SEG_W  = 5;
  localparam int DIV_CNT_W = $clog2(FRAC_W);

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] FMT_U16 = 2'd0;
  localparam logic [1:0] FMT_U32 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  localparam logic [VAL_W-1:0]  SIGN_FLIP = 32'h8000_0000;
  localparam logic [FRAC_W-1:0] FRAC_MAX  = 16'hffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_TOP,
    ST_MID,
    ST_STEP,
    ST_INC,
    ST_NORM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             borrow;
    logic [VAL_W-1:0] diff;
  } sub_res_t;

  // Maps a raw value onto an unsigned key whose order and differences match
  // the table format. The unused fourth code reads like uint32.
  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] raw,
                                                 input logic [1:0] fmt);
    logic [VAL_W-1:0] k;
    unique case (fmt)
      FMT_U16: k = {16'h0000, raw[15:0]};
      FMT_U32: k = raw;
      FMT_S32: k = raw ^ SIGN_FLIP;
      default: k = raw;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/bsf_bp_mem.sv
// ---------------------------------------------------------------------------
// Breakpoint memory
// One write port and one registered read port holding every table.
// ---------------------------------------------------------------------------
module bsf_bp_mem import bsf_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [VAL_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [VAL_W-1:0]  rd_data
);

  logic [VAL_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bsf_sub.sv
// ---------------------------------------------------------------------------
// Shared subtractor
// Difference with borrow, used for compares, step sizes and divide steps.
// ---------------------------------------------------------------------------
module bsf_sub import bsf_pkg::*; (
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output sub_res_t         res
);

  // The borrow is set exactly when a is below b.
  assign {res.borrow, res.diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> rtl/breakpoint_segment_fraction_unit.sv
// ---------------------------------------------------------------------------
// Breakpoint segment fraction unit
// Sorted breakpoint tables with a bisecting lookup and a fractional position.
// ---------------------------------------------------------------------------
// Holds four breakpoint tables of up to 32 points. A load word (op 0) writes
// one point and the table format and gives no result. A
// lookup word (op 1) searches the chosen table for the segment with
// bp[i] <= x < bp[i+1] and returns the lower index together with the
// position inside that segment in 65536ths. While a lookup is in progress
// the input is not ready; only one word is worked on at a time. A lookup on
// a short table offers its result word in the cycle straight after it was
// accepted. Otherwise it first compares the value with the first point and
// then with the last point, either of which can end the lookup. In range,
// it bisects in floor or ceil of log2(n-1) steps for n points, at most 5,
// takes both differences and narrows a step wider than 16 bits by at most
// 9 normalising shifts (a step of 25 bits or more first drops by eight
// places at once) before a restoring divide. When the narrowed increment
// equals the step the fraction saturates and the divide is skipped. The
// breakpoint memory has one read port and sets the pace of the search,
// with one point read per cycle, and a single subtractor carries every
// compare, both differences and the 16 restoring divide steps.
// There is no clearing pass after reset: table sizes and formats reset to
// zero at once, and breakpoints are only defined once loaded.
// ---------------------------------------------------------------------------
`include "breakpoint_segment_fraction_unit_assert.svh"

module breakpoint_segment_fraction_unit import bsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [4:0] point_index, [36:5] value, [38:37] value_format, [39] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op, [2:1] table_sel
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [4:0] segment_index, [20:5] fraction, [23:21] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] in_range, [1] table_error
  output logic [OUT_USER_W-1:0] m_tuser
);

  // Input word fields.
  logic              in_op;
  logic [1:0]        in_tsel;
  logic [4:0]        in_pidx;
  logic [VAL_W-1:0]  in_value;
  logic [1:0]        in_fmt;
  logic              in_last;

  assign in_op    = s_tuser[0];
  assign in_tsel  = s_tuser[2:1];
  assign in_pidx  = s_tdata[4:0];
  assign in_value = s_tdata[36:5];
  assign in_fmt   = s_tdata[38:37];
  assign in_last  = s_tlast;

  // Sequencer and table state.
  state_t            state, state_next;
  logic [CNT_W-1:0]  table_points [NUM_TABLES];
  logic [1:0]        table_format [NUM_TABLES];

  // Lookup working registers.
  logic [TBL_W-1:0]  tsel;
  logic [1:0]        fmt;
  logic [CNT_W-1:0]  npts;
  logic [VAL_W-1:0]  x, lo_key, hi_key, step, inc;
  logic [PTR_W-1:0]  lo, hi, mid;
  logic [FRAC_W-1:0] rem, quot;
  logic [DIV_CNT_W-1:0] cnt;

  // Output register.
  logic [SEG_W-1:0]  res_seg;
  logic [FRAC_W-1:0] res_frac;
  logic              res_inr, res_err;

  // Handshake and decode of the current word.
  logic              acc, acc_load, acc_look;
  logic              in_tsel_ok, in_pidx_ok;
  logic [TBL_W-1:0]  in_tidx;
  logic [PTR_W-1:0]  in_pptr;
  logic [CNT_W-1:0]  look_npts;
  logic              look_err;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign acc      = s_tvalid && s_tready;
  assign acc_load = acc && (in_op == OP_LOAD);
  assign acc_look = acc && (in_op == OP_LOOKUP);

  assign in_tsel_ok = (32'(in_tsel) < NUM_TABLES);
  assign in_pidx_ok = (32'(in_pidx) < MAX_POINTS);
  assign in_tidx    = in_tsel[TBL_W-1:0];
  assign in_pptr    = in_pidx[PTR_W-1:0];
  assign look_npts  = table_points[in_tidx];
  assign look_err   = !in_tsel_ok || (32'(look_npts) < 2) || (32'(look_npts) > MAX_POINTS);

  // Breakpoint memory: loads write straight from the input word.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;
  logic [VAL_W-1:0]  rd_key;

  bsf_bp_mem u_mem (
    .clk     (clk),
    .wr_en   (acc_load && in_tsel_ok && in_pidx_ok),
    .wr_addr ({in_tidx, in_pptr}),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key = order_key(rd_data, fmt);

  // The one subtractor; its operands are chosen by the sequencer state.
  logic [VAL_W-1:0]  sub_a, sub_b;
  sub_res_t          sub;

  bsf_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub)
  );

  // Bisection bookkeeping. In the search state the subtractor compares the
  // key of bp[mid] against x; a clear borrow means bp[mid] <= x.
  logic              le_mid;
  logic [PTR_W-1:0]  new_lo, new_hi, mid_new;
  logic [PTR_W-1:0]  top_ptr, mid_top;
  logic              more_new;
  logic [FRAC_W:0]   div_sh;

  assign le_mid   = !sub.borrow;
  assign new_lo   = le_mid ? mid : lo;
  assign new_hi   = le_mid ? hi : mid;
  assign more_new = ((new_hi - new_lo) > PTR_W'(1));
  assign mid_new  = PTR_W'(({1'b0, new_lo} + {1'b0, new_hi}) >> 1);
  assign top_ptr  = PTR_W'(npts - CNT_W'(1));
  assign mid_top  = top_ptr >> 1;
  assign div_sh   = {rem, 1'b0};

  always_comb begin
    sub_a = x;
    sub_b = lo_key;
    unique case (state)
      ST_FIRST, ST_TOP, ST_MID: begin
        sub_a = x;
        sub_b = rd_key;
      end
      ST_STEP: begin
        sub_a = hi_key;
        sub_b = lo_key;
      end
      ST_DIV: begin
        sub_a = VAL_W'(div_sh);
        sub_b = {16'h0000, step[15:0]};
      end
      default: begin
        sub_a = x;
        sub_b = lo_key;
      end
    endcase
  end

  // Next state and memory read requests.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = {tsel, PTR_W'(0)};
    unique case (state)
      ST_IDLE: begin
        if (acc_look) begin
          if (look_err) begin
            state_next = ST_OUT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = {in_tidx, PTR_W'(0)};
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (sub.borrow) begin
          state_next = ST_OUT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = {tsel, top_ptr};
          state_next = ST_TOP;
        end
      end
      ST_TOP: begin
        if (!sub.borrow) begin
          state_next = ST_OUT;
        end else if (top_ptr > PTR_W'(1)) begin
          rd_en      = 1'b1;
          rd_addr    = {tsel, mid_top};
          state_next = ST_MID;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_MID: begin
        if (more_new) begin
          rd_en   = 1'b1;
          rd_addr = {tsel, mid_new};
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: state_next = ST_INC;
      ST_INC:  state_next = ST_NORM;
      ST_NORM: begin
        if (step[31:16] == 16'h0000) begin
          state_next = (inc[15:0] == step[15:0]) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == DIV_CNT_W'(FRAC_W - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, table sizes and formats.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      table_points <= '{default: '0};
      table_format <= '{default: '0};
    end else begin
      state <= state_next;
      if (acc_load && in_tsel_ok && in_pidx_ok) begin
        table_format[in_tidx] <= in_fmt;
        if (in_last) begin
          table_points[in_tidx] <= CNT_W'(in_pptr) + CNT_W'(1);
        end
      end
    end
  end

  // Lookup datapath. The result register starts cleared for every lookup so
  // that the short-table and below-range cases need no further writes.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (acc_look) begin
          tsel     <= in_tidx;
          fmt      <= table_format[in_tidx];
          npts     <= look_npts;
          x        <= order_key(in_value, table_format[in_tidx]);
          res_seg  <= '0;
          res_frac <= '0;
          res_inr  <= 1'b0;
          res_err  <= look_err;
        end
      end
      ST_FIRST: lo_key <= rd_key;
      ST_TOP: begin
        hi_key <= rd_key;
        lo     <= '0;
        hi     <= top_ptr;
        mid    <= mid_top;
        if (!sub.borrow) begin
          res_seg  <= SEG_W'(npts - CNT_W'(2));
          res_frac <= FRAC_MAX;
        end
      end
      ST_MID: begin
        lo  <= new_lo;
        hi  <= new_hi;
        mid <= mid_new;
        if (le_mid) begin
          lo_key <= rd_key;
        end else begin
          hi_key <= rd_key;
        end
      end
      ST_STEP: step <= sub.diff;
      ST_INC:  inc  <= sub.diff;
      ST_NORM: begin
        // Shifting by eight and then by one gives the same total as
        // repeated single shifts, since the floors compose.
        if (step[31:24] != 8'h00) begin
          step <= step >> 8;
          inc  <= inc >> 8;
        end else if (step[31:16] != 16'h0000) begin
          step <= step >> 1;
          inc  <= inc >> 1;
        end else begin
          rem      <= inc[15:0];
          quot     <= '0;
          cnt      <= '0;
          res_seg  <= SEG_W'(lo);
          res_inr  <= 1'b1;
          res_frac <= FRAC_MAX;
        end
      end
      ST_DIV: begin
        rem  <= sub.borrow ? div_sh[FRAC_W-1:0] : sub.diff[FRAC_W-1:0];
        quot <= {quot[FRAC_W-2:0], !sub.borrow};
        cnt  <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(FRAC_W - 1)) begin
          res_frac <= {quot[FRAC_W-2:0], !sub.borrow};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {3'b000, res_frac, res_seg};
  assign m_tuser = {res_err, res_inr};

  // A lookup holds the input off until its result word has been taken.
  `BSF_ASSERT(a_one_word_in_flight, !(s_tready && m_tvalid), "input ready while result pending")
  `BSF_ASSERT(a_lookup_blocks, (acc_look |=> !s_tready), "ready straight after a lookup")
  // A table error clears every other result field.
  `BSF_ASSERT(a_error_clean, ((m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0])), "error result not clean")
  // An out-of-range result is clamped to one end of the table.
  `BSF_ASSERT(a_clamp_ends, ((m_tvalid && !m_tuser[1] && !m_tuser[0]) |-> ((m_tdata == '0) || (m_tdata[20:5] == FRAC_MAX))), "clamped result not at an end")
  `BSF_ASSERT_ALWAYS(a_reset_idle, (rst |=> (s_tready && !m_tvalid)), "not idle after reset")

endmodule
